// File: hw/rtl/small_key_value_table_unit_macros.svh
// Assertion shorthands, clocked on clk_i and disabled in reset.
`ifndef SMALL_KEY_VALUE_TABLE_UNIT_MACROS_SVH
`define SMALL_KEY_VALUE_TABLE_UNIT_MACROS_SVH

`define SKVT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SKVT_NEVER(lbl, cond, msg) \
  `SKVT_CHECK(lbl, (!(cond)), msg)

`endif

// File: hw/rtl/skvt_pkg.sv
`default_nettype none

package skvt_pkg;

  localparam int unsigned KeyWidth   = 8;
  localparam int unsigned ValueWidth = 32;

  localparam int unsigned InDataWidth  = ((KeyWidth + ValueWidth + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = ((ValueWidth + 7) / 8) * 8;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  full;
    logic                  hit;
    logic [ValueWidth-1:0] value;
  } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/skvt_front.sv
`default_nettype none

module skvt_front import skvt_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  input  wire logic [InDataWidth-1:0] s_tdata_i,
  input  wire logic [0:0]             s_tuser_i,
  output logic                        req_valid_o,
  input  wire logic                   req_ready_i,
  output req_t                        req_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_ptr_q, rd_ptr_q;
  req_t            buf_q [Depth];
  req_t            in_req;
  logic            push, pop;

  // decode the incoming request
  always_comb begin
    in_req       = '0;
    in_req.op    = (s_tuser_i[0] == 1'b1) ? OP_SET : OP_GET;
    in_req.key   = s_tdata_i[KeyWidth-1:0];
    in_req.value = s_tdata_i[KeyWidth+ValueWidth-1:KeyWidth];
  end

  assign s_tready_o  = (cnt_q != CntW'(Depth));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = buf_q[rd_ptr_q];

  assign push = s_tvalid_i && s_tready_o;
  assign pop  = req_valid_o && req_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_req;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/skvt_back.sv
`default_nettype none

module skvt_back import skvt_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  req_t      req_i,
  output logic      m_tvalid_o,
  input  wire logic m_tready_i,
  output rsp_t      rsp_o
);

  localparam int unsigned KeyW = (KEY_BITS < KeyWidth) ? KEY_BITS : KeyWidth;
  localparam int unsigned ValW = (VALUE_BITS < ValueWidth) ? VALUE_BITS : ValueWidth;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic            state_q, state_d;
  req_t            req_q, req_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_pend_q, rd_pend_d;
  logic            out_vld_q, out_vld_d;
  rsp_t            rsp_q, rsp_d;

  logic [KeyW-1:0] key_mem [ENTRIES];
  logic [ValW-1:0] val_mem [ENTRIES];
  logic [KeyW-1:0] key_rd_q;
  logic [ValW-1:0] val_rd_q;

  logic                   key_we, val_we, issue;
  logic [IdxW-1:0]        wr_idx;
  logic                   hit_now, out_free, tbl_full;
  logic signed [ValW-1:0] rd_sval;

  // entries [0, cnt_q) are exactly the valid ones: free slots fill in order
  assign hit_now  = rd_pend_q && (key_rd_q == req_q.key[KeyW-1:0]);
  assign out_free = !out_vld_q || m_tready_i;
  assign tbl_full = (cnt_q == CntW'(ENTRIES));
  assign rd_sval  = val_rd_q;

  assign req_ready_o = (state_q == ST_IDLE);
  assign m_tvalid_o  = out_vld_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    scan_d    = scan_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    rd_pend_d = rd_pend_q;
    out_vld_d = out_vld_q;
    rsp_d     = rsp_q;
    key_we    = 1'b0;
    val_we    = 1'b0;
    issue     = 1'b0;
    wr_idx    = rd_idx_q;
    if (out_vld_q && m_tready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d     = req_i;
          scan_d    = '0;
          rd_pend_d = 1'b0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now || (scan_q == cnt_q)) begin
          if (out_free) begin
            out_vld_d = 1'b1;
            state_d   = ST_IDLE;
            rsp_d     = '0;
            rsp_d.hit = hit_now;
            if (req_q.op == OP_GET) begin
              if (hit_now) begin
                rsp_d.value = ValueWidth'(rd_sval);
              end
            end else if (hit_now) begin
              val_we = 1'b1;
            end else if (!tbl_full) begin
              key_we = 1'b1;
              val_we = 1'b1;
              wr_idx = cnt_q[IdxW-1:0];
              cnt_d  = cnt_q + 1'b1;
            end else begin
              rsp_d.full = 1'b1;
            end
          end
        end else begin
          issue     = 1'b1;
          rd_idx_d  = scan_q[IdxW-1:0];
          scan_d    = scan_q + 1'b1;
          rd_pend_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      cnt_q     <= cnt_d;
      rd_idx_q  <= rd_idx_d;
      rd_pend_q <= rd_pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= req_q.key[KeyW-1:0];
    end
    if (val_we) begin
      val_mem[wr_idx] <= req_q.value[ValW-1:0];
    end
    if (issue) begin
      key_rd_q <= key_mem[scan_q[IdxW-1:0]];
      val_rd_q <= val_mem[scan_q[IdxW-1:0]];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/small_key_value_table_unit.sv
// Channel  | Dir | tdata                               | tuser
// s_axis   | in  | [7:0] lookup_key, [39:8] new_value  | [0] func (0 get, 1 set)
// m_axis   | out | [31:0] read_value                   | [0] hit, [1] full_res
//
// A request in the table engine reads the filled entries in order until a
// match or, on a miss, through every filled entry; the single-port
// key/value memory reads one entry a cycle.
// A two-deep request queue lets s_axis accept up to two requests while the engine works.
// Reset clears the fill count, so the table starts empty; no clearing pass.
// A stalled m_axis holds the engine at its final step.
`default_nettype none

module small_key_value_table_unit import skvt_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire logic [InDataWidth-1:0]  s_axis_tdata_i,  // lookup_key, new_value
  input  wire logic [0:0]              s_axis_tuser_i,  // func
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  output logic [OutDataWidth-1:0]      m_axis_tdata_o,  // read_value
  output logic [1:0]                   m_axis_tuser_o   // hit, full_res
);

  logic req_valid, req_ready;
  req_t req;
  rsp_t rsp;

  skvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  skvt_back #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .rsp_o       (rsp)
  );

  assign m_axis_tdata_o = OutDataWidth'(rsp.value);
  assign m_axis_tuser_o = {rsp.full, rsp.hit};

endmodule

`default_nettype wire

// File: hw/rtl/skvt_checker.sv
`default_nettype none
`include "small_key_value_table_unit_macros.svh"

module skvt_checker import skvt_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    m_axis_tvalid_o,
  input wire logic                    m_axis_tready_i,
  input wire logic [OutDataWidth-1:0] m_axis_tdata_o,
  input wire logic [1:0]              m_axis_tuser_o
);

  `SKVT_CHECK(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)), "response changed while stalled")
  `SKVT_NEVER(a_hit_full, (m_axis_tvalid_o && m_axis_tuser_o[0] && m_axis_tuser_o[1]), "hit and full together")
  `SKVT_CHECK(a_value_hit, (m_axis_tvalid_o && m_axis_tdata_o != '0 |-> m_axis_tuser_o[0]), "value without hit")
  `SKVT_CHECK(a_full_zero, (m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o == '0), "dropped set with value")

endmodule

bind small_key_value_table_unit skvt_checker u_checker (.*);

`default_nettype wire
